// ----- rtl/bdlp_pkg.sv -----
package bdlp_pkg;

  // Event codes reported with each sample
  typedef enum logic [2:0] {
    EV_IDLE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_RELEASED = 3'd2,
    EV_HELD     = 3'd3,
    EV_NA       = 3'd4
  } event_t;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE     = 2'd0;
  localparam logic [1:0] REG_PULL_UP    = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE   = 2'd2;
  localparam logic [1:0] REG_LONG_PRESS = 2'd3;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned IN_DW    = 24;
  localparam int unsigned OUT_DW   = 8;

  localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [TIME_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef struct packed {
    logic              enable;
    logic              pull_up;
    logic [TIME_W-1:0] settle_ms;
    logic [TIME_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              raw_level;
    logic              clear_hold;
  } sample_t;

  typedef struct packed {
    event_t event_res;
    logic   was_held;
    logic   holding;
  } result_t;

endpackage

// ----- rtl/bdlp_cfg_regs.sv -----
module bdlp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bdlp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::TIME_W-1:0]  cfg_data,
  output bdlp_pkg::cfg_t               cfg,
  output logic                         pull_up_wr
);

  bdlp_pkg::cfg_t cfg_r;

  assign cfg        = cfg_r;
  assign pull_up_wr = cfg_we && (cfg_index == bdlp_pkg::REG_PULL_UP);

  // Hold the control registers, update on a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= 1'b0;
      cfg_r.pull_up       <= 1'b0;
      cfg_r.settle_ms     <= bdlp_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms <= bdlp_pkg::LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdlp_pkg::REG_ENABLE:     cfg_r.enable        <= cfg_data[0];
        bdlp_pkg::REG_PULL_UP:    cfg_r.pull_up       <= cfg_data[0];
        bdlp_pkg::REG_DEBOUNCE:   cfg_r.settle_ms     <= cfg_data;
        bdlp_pkg::REG_LONG_PRESS: cfg_r.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/bdlp_core.sv -----
module bdlp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  bdlp_pkg::cfg_t      cfg,
  input  logic                pull_up_wr,
  input  logic                pull_up_val,
  input  logic                fire,
  input  bdlp_pkg::sample_t   smp,
  output bdlp_pkg::result_t   res
);

  logic                        last_raw_r, last_raw_nxt;
  logic                        stable_r, stable_nxt;
  logic [bdlp_pkg::TIME_W-1:0] change_time_r, change_time_nxt;
  logic [bdlp_pkg::TIME_W-1:0] press_start_r, press_start_nxt;
  logic                        hold_mark_r, hold_mark_nxt;
  logic                        holding_r, holding_nxt;

  logic [bdlp_pkg::TIME_W-1:0] since_change;
  logic [bdlp_pkg::TIME_W-1:0] since_press;
  logic                        settled;
  bdlp_pkg::event_t            ev;

  // Elapsed times wrap modulo the timestamp width
  assign since_change = smp.now_ms - change_time_nxt;
  assign since_press  = smp.now_ms - press_start_r;

  // Evaluate one sample against the stored button state
  always_comb begin
    last_raw_nxt    = last_raw_r;
    stable_nxt      = stable_r;
    change_time_nxt = change_time_r;
    press_start_nxt = press_start_r;
    hold_mark_nxt   = smp.clear_hold ? 1'b0 : hold_mark_r;
    holding_nxt     = holding_r;
    settled         = 1'b0;
    ev              = bdlp_pkg::EV_IDLE;

    if (!cfg.enable) begin
      ev = bdlp_pkg::EV_NA;
    end else begin
      // Restart the debounce timer on a raw edge
      if (smp.raw_level != last_raw_r) begin
        change_time_nxt = smp.now_ms;
        last_raw_nxt    = smp.raw_level;
      end
      // Accept a level that stayed put long enough
      if ((since_change > cfg.settle_ms) && (smp.raw_level != stable_r)) begin
        stable_nxt = smp.raw_level;
        settled    = 1'b1;
        if (smp.raw_level ^ cfg.pull_up) begin
          press_start_nxt = smp.now_ms;
          hold_mark_nxt   = 1'b0;
          ev              = bdlp_pkg::EV_PRESSED;
        end else begin
          holding_nxt = 1'b0;
          ev          = bdlp_pkg::EV_RELEASED;
        end
      end
      // Report a long press while the stable level stays active
      if (!settled && (stable_r ^ cfg.pull_up) && (since_press >= cfg.long_press_ms)) begin
        holding_nxt   = 1'b1;
        hold_mark_nxt = 1'b1;
        ev            = bdlp_pkg::EV_HELD;
      end
    end
  end

  assign res.event_res = ev;
  assign res.was_held  = hold_mark_nxt;
  assign res.holding   = holding_nxt;

  // Advance the state on each processed request; a mode change reloads the levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b0;
      stable_r      <= 1'b0;
      change_time_r <= '0;
      press_start_r <= '0;
      hold_mark_r   <= 1'b0;
      holding_r     <= 1'b0;
    end else if (pull_up_wr) begin
      last_raw_r <= pull_up_val;
      stable_r   <= pull_up_val;
    end else if (fire) begin
      last_raw_r    <= last_raw_nxt;
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
      press_start_r <= press_start_nxt;
      hold_mark_r   <= hold_mark_nxt;
      holding_r     <= holding_nxt;
    end
  end

endmodule

// ----- rtl/button_debounce_long_press.sv -----
// Channel  Ports                       Payload
// -------  --------------------------  ---------------------------------------------
// in       in_tvalid/in_tready/tdata   now_ms[15:0] raw_level[16] clear_hold[17]
// out      out_tvalid/out_tready/tdata event_res[2:0] was_held[3] holding[4]
// cfg      cfg_we/cfg_index/cfg_data   0 enable, 1 pull_up, 2 settle_ms, 3 long_press_ms
//
// One sample per clock sustained while out_tready stays high; two register stages
// (input register, then the evaluation into the result register), and a stall on
// out_tready can keep the accepted request waiting in the input register.
// The state update and the result are computed in the same single cycle.
// Reset is synchronous on rst_n and empties both pipeline registers.
// A stall on out_tready holds the result register; the input register still
// takes a request when the result register is free or being drained.
module button_debounce_long_press (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bdlp_pkg::IN_DW-1:0]   in_tdata,   // now_ms, raw_level, clear_hold
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bdlp_pkg::OUT_DW-1:0]  out_tdata,  // event_res, was_held, holding
  input  logic                         cfg_we,
  input  logic [bdlp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::TIME_W-1:0]  cfg_data
);

  bdlp_pkg::cfg_t    cfg;
  logic              pull_up_wr;
  logic              in_valid_r;
  bdlp_pkg::sample_t in_smp_r;
  logic              out_valid_r;
  bdlp_pkg::result_t out_res_r;
  bdlp_pkg::result_t res;
  logic              fire;

  bdlp_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .pull_up_wr (pull_up_wr)
  );

  bdlp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .pull_up_wr  (pull_up_wr),
    .pull_up_val (cfg_data[0]),
    .fire        (fire),
    .smp         (in_smp_r),
    .res         (res)
  );

  // Move the held request on when the result register can take it
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_smp_r.now_ms     <= in_tdata[15:0];
      in_smp_r.raw_level  <= in_tdata[16];
      in_smp_r.clear_hold <= in_tdata[17];
    end
  end

  // Result register: load on fire, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.holding, out_res_r.was_held, out_res_r.event_res};

endmodule

// ----- dv/bdlp_checker.sv -----
// Scoreboard for the button debounce block: tracks register writes and sample
// requests, predicts one result per sample and compares it with the result
// stream in order.
module bdlp_checker
  import bdlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DW-1:0]     in_tdata,   // now_ms[15:0], raw_level[16], clear_hold[17]
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OUT_DW-1:0]    out_tdata,  // event_res[2:0], was_held[3], holding[4]
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  output int unsigned          fail_count,
  output int unsigned          outstanding
);

  // Register copies
  logic              en_q;
  logic              pull_up_q;
  logic [TIME_W-1:0] debounce_q;
  logic [TIME_W-1:0] long_press_q;

  // Button state copies
  logic              last_raw;
  logic              stable;
  logic [TIME_W-1:0] change_t;
  logic [TIME_W-1:0] press_t;
  logic              hold_mark;
  logic              holding_flag;

  result_t     expected_events[$];
  int unsigned results_seen;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    fail_count++;
  endtask

  // Evaluate one sample against the tracked button state
  task automatic debounce_step(input logic [TIME_W-1:0] now, input logic raw,
                               input logic clr, output result_t res);
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic              settled;
    event_t            ev;
    ev      = EV_IDLE;
    settled = 1'b0;
    if (clr) hold_mark = 1'b0;
    if (!en_q) begin
      ev = EV_NA;
    end else begin
      // restart the debounce timer on any raw change
      if (raw != last_raw) begin
        change_t = now;
        last_raw = raw;
      end
      since_change = now - change_t;
      if (since_change > debounce_q && raw != stable) begin
        stable  = raw;
        settled = 1'b1;
        if (raw ^ pull_up_q) begin
          press_t   = now;
          hold_mark = 1'b0;
          ev        = EV_PRESSED;
        end else begin
          holding_flag = 1'b0;
          ev           = EV_RELEASED;
        end
      end
      // long press: held event on every sample past the threshold while the stable level is active and none settles
      since_press = now - press_t;
      if (!settled && (stable ^ pull_up_q) && since_press >= long_press_q) begin
        holding_flag = 1'b1;
        hold_mark    = 1'b1;
        ev           = EV_HELD;
      end
    end
    res.event_res = ev;
    res.was_held  = hold_mark;
    res.holding   = holding_flag;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    event_t  got_ev;
    if (!rst_n) begin
      en_q         = 1'b0;
      pull_up_q    = 1'b0;
      debounce_q   = DEBOUNCE_RST;
      long_press_q = LONG_PRESS_RST;
      last_raw     = 1'b0;
      stable       = 1'b0;
      change_t     = '0;
      press_t      = '0;
      hold_mark    = 1'b0;
      holding_flag = 1'b0;
      expected_events.delete();
      outstanding <= 0;
    end else begin
      // apply register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:     en_q = cfg_data[0];
          REG_PULL_UP: begin
            pull_up_q = cfg_data[0];
            last_raw  = cfg_data[0];
            stable    = cfg_data[0];
          end
          REG_DEBOUNCE:   debounce_q   = cfg_data;
          REG_LONG_PRESS: long_press_q = cfg_data;
          default: ;
        endcase
      end
      // compare a delivered result with the oldest expectation
      if (out_tvalid && out_tready) begin
        results_seen++;
        got_ev = event_t'(out_tdata[2:0]);
        if (expected_events.size() == 0) begin
          report("result with no request pending, event", got_ev, 0);
        end else begin
          want = expected_events.pop_front();
          if (got_ev != want.event_res) report("event_res", got_ev, want.event_res);
          if (out_tdata[3] != want.was_held) report("was_held", out_tdata[3], want.was_held);
          if (out_tdata[4] != want.holding) report("holding", out_tdata[4], want.holding);
        end
      end
      // predict for an accepted request
      if (in_tvalid && in_tready) begin
        debounce_step(in_tdata[15:0], in_tdata[16], in_tdata[17], fresh);
        expected_events.push_back(fresh);
      end
      outstanding <= expected_events.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  import bdlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_GOAL   = 1700;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;   // now_ms[15:0], raw_level[16], clear_hold[17]
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;  // event_res[2:0], was_held[3], holding[4]
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [TIME_W-1:0]   cfg_data;

  int unsigned         fail_count;
  int unsigned         outstanding;
  int unsigned         cycles;
  int unsigned         samples_sent;
  logic [TIME_W-1:0]   clock_ms;
  logic                cur_pull_up;
  logic                no_gaps;

  button_debounce_long_press uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bdlp_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each result
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Issue one sample request after a random gap; return at its accept edge
  task automatic send_sample(input logic [TIME_W-1:0] t, input logic lvl, input logic clr);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, clr, lvl, t};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Hold off the sender until every expected result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Write the registers selected by mask; call only when drained
  task automatic set_regs(input logic en, input logic pu, input logic [TIME_W-1:0] deb,
                          input logic [TIME_W-1:0] lp, input logic [3:0] mask);
    if (mask[REG_ENABLE])     write_reg(REG_ENABLE, {15'b0, en});
    if (mask[REG_PULL_UP]) begin
      write_reg(REG_PULL_UP, {15'b0, pu});
      cur_pull_up = pu;
    end
    if (mask[REG_DEBOUNCE])   write_reg(REG_DEBOUNCE, deb);
    if (mask[REG_LONG_PRESS]) write_reg(REG_LONG_PRESS, lp);
    cfg_we <= 1'b0;
  endtask

  task automatic sample_at(input int tick_max, input logic lvl);
    clock_ms += TIME_W'($urandom_range(0, tick_max));
    send_sample(clock_ms, lvl, ($urandom_range(0, 7) == 0));
  endtask

  // Bounce a little, then sit at one level for a while
  task automatic hold_level(input logic lvl, input int tick_max);
    int n;
    n = $urandom_range(0, 4);
    repeat (n) sample_at(tick_max, 1'($urandom_range(0, 1)));
    n = $urandom_range(1, 30);
    repeat (n) sample_at(tick_max, lvl);
  endtask

  initial begin
    int               phase_len;
    int               phase_start;
    int               tick_max;
    logic             en;
    logic             pu;
    logic [TIME_W-1:0] deb;
    logic [TIME_W-1:0] lp;
    cycles       = 0;
    samples_sent = 0;
    clock_ms     = '0;
    cur_pull_up  = 1'b0;
    no_gaps      = 1'b0;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_ENABLE;
    cfg_data     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // disabled after reset: not available, clear request still applies
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b1);
    drain();

    // zero debounce, short long press, active-high button
    set_regs(1'b1, 1'b0, 16'd0, 16'd3, 4'hF);
    send_sample(16'd100, 1'b1, 1'b0);
    send_sample(16'd101, 1'b1, 1'b0);
    send_sample(16'd102, 1'b1, 1'b0);
    send_sample(16'd104, 1'b1, 1'b0);
    send_sample(16'd105, 1'b1, 1'b1);
    send_sample(16'd106, 1'b0, 1'b0);
    send_sample(16'd107, 1'b0, 1'b0);
    send_sample(16'd108, 1'b0, 1'b1);
    // press across the timestamp wrap
    send_sample(16'd65534, 1'b1, 1'b0);
    send_sample(16'd1, 1'b1, 1'b0);
    send_sample(16'd2, 1'b0, 1'b0);
    send_sample(16'd3, 1'b0, 1'b0);
    drain();

    // active-low mode with a debounce time that can never elapse
    set_regs(1'b1, 1'b1, 16'hFFFF, 16'd0, 4'hF);
    send_sample(16'd10, 1'b0, 1'b0);
    send_sample(16'd60000, 1'b0, 1'b1);
    drain();

    // keep the button state, change only the times: maximum long press
    set_regs(1'b1, 1'b1, 16'd0, 16'hFFFF, 4'b1100);
    send_sample(16'd20, 1'b0, 1'b0);
    send_sample(16'd21, 1'b0, 1'b0);
    send_sample(16'd19, 1'b0, 1'b0);
    send_sample(16'd22, 1'b1, 1'b0);
    send_sample(16'd23, 1'b1, 1'b0);
    drain();

    // disable with state held
    set_regs(1'b0, 1'b0, 16'd0, 16'd0, 4'b0001);
    send_sample(16'd30, 1'b0, 1'b1);
    drain();

    // random phases: new settings, then press/release episodes and noise
    while (samples_sent < ITEM_GOAL) begin
      en = ($urandom_range(0, 7) != 0);
      pu = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0:       deb = '0;
        1:       deb = 16'hFFFF;
        2:       deb = TIME_W'($urandom);
        default: deb = TIME_W'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 7))
        0:       lp = '0;
        1:       lp = 16'hFFFF;
        2:       lp = TIME_W'($urandom);
        default: lp = TIME_W'($urandom_range(1, 400));
      endcase
      set_regs(en, pu, deb, lp, 4'($urandom_range(1, 15)));
      no_gaps     = ($urandom_range(0, 3) == 0);
      tick_max    = $urandom_range(1, 40);
      phase_len   = $urandom_range(60, 200);
      phase_start = samples_sent;
      while (samples_sent - phase_start < phase_len) begin
        if ($urandom_range(0, 9) < 2) begin
          // noise: random levels, random clear requests, occasional time jumps
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 3) == 0) clock_ms = TIME_W'($urandom);
            else clock_ms += TIME_W'($urandom_range(0, tick_max));
            send_sample(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end else begin
          hold_level(~cur_pull_up, tick_max);
          hold_level(cur_pull_up, tick_max);
        end
      end
      drain();
    end

    no_gaps = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
